// ----- hdl/dq_pkg.sv -----
// Shared types and codes for the double-ended queue.
`default_nettype none
package dq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_LIST       = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]               kind;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] value_res;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic empty;
      logic full;
   } stat_type;

endpackage
`default_nettype wire

// ----- hdl/dq_mem.sv -----
// Entry storage: one write port and one read port with registered read data.
`default_nettype none
module dq_mem #(
   parameter int DEPTH = dq_pkg::CAPACITY_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [IDX_W-1:0]                 wr_addr,
   input  wire logic signed [dq_pkg::DATA_W-1:0] wr_data,
   input  wire logic                             rd_en,
   input  wire logic [IDX_W-1:0]                 rd_addr,
   output logic signed [dq_pkg::DATA_W-1:0]      rd_data
);
   import dq_pkg::*;

   logic signed [DATA_W-1:0] mem_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Read data holds while no read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- hdl/dq_ctrl.sv -----
// Command sequencer: ring pointers, memory access and the result register.
`default_nettype none
module dq_ctrl #(
   parameter int CAPACITY = dq_pkg::CAPACITY_DEF,
   parameter int IDX_W    = $clog2(CAPACITY)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire dq_pkg::req_type                  req_item,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output dq_pkg::rsp_type                       rsp_item,
   output logic                                  wr_en,
   output logic [IDX_W-1:0]                      wr_addr,
   output logic signed [dq_pkg::DATA_W-1:0]      wr_data,
   output logic                                  rd_en,
   output logic [IDX_W-1:0]                      rd_addr,
   input  wire logic signed [dq_pkg::DATA_W-1:0] rd_data,
   output dq_pkg::stat_type                      stat
);
   import dq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);
   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   typedef enum logic {S_IDLE, S_BUSY} state_type;

   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (IDX_W + 1)'(CAPACITY)) begin
         s = s - (IDX_W + 1)'(CAPACITY);
      end
      return s[IDX_W-1:0];
   endfunction

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic             pend_ff, pend_in;
   logic             pend_last_ff, pend_last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_item_ff, rsp_item_in;

   logic             out_free;
   logic             accept;
   logic             is_empty;
   logic             is_full;
   logic [CNT_W-1:0] count_m1;
   logic [IDX_W-1:0] head_dec;
   logic [IDX_W-1:0] tail_pos;
   logic [IDX_W-1:0] back_pos;
   logic             load;
   logic             issue;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CAP_CNT);
   assign count_m1  = count_ff - ONE_CNT;
   assign head_dec  = (head_ff == '0) ? LAST_IDX : head_ff - ONE_IDX;
   // Both offsets stay below the capacity whenever they are used.
   assign tail_pos  = ring_add(head_ff, count_ff[IDX_W-1:0]);
   assign back_pos  = ring_add(head_ff, count_m1[IDX_W-1:0]);

   // The read data register is a stage of its own: it is refilled only
   // when its item moves to the result register or it is empty.
   assign load  = (state_ff == S_BUSY) && pend_ff && out_free;
   assign issue = (state_ff == S_BUSY) && (rem_ff != '0) && (!pend_ff || load);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      wr_addr      = head_dec;
      wr_data      = req_item.value;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_item.kind) inside
                  KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     rsp_item_in  = '{status: STAT_FULL, value_res: '0, last: 1'b1};
                     if (!is_full) begin
                        rsp_item_in.status = STAT_OK;
                        wr_en    = 1'b1;
                        count_in = count_ff + ONE_CNT;
                        if (req_item.kind == KIND_PUSH_FRONT) begin
                           wr_addr = head_dec;
                           head_in = head_dec;
                        end else begin
                           wr_addr = tail_pos;
                        end
                     end
                  end
                  KIND_POP_FRONT, KIND_POP_BACK, KIND_LIST: begin
                     if (is_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_item_in  = '{status: STAT_EMPTY, value_res: '0, last: 1'b1};
                     end else begin
                        rd_en        = 1'b1;
                        pend_in      = 1'b1;
                        pend_last_in = 1'b1;
                        rem_in       = '0;
                        state_in     = S_BUSY;
                        if (req_item.kind == KIND_POP_FRONT) begin
                           rd_addr  = head_ff;
                           head_in  = ring_add(head_ff, ONE_IDX);
                           count_in = count_m1;
                        end else if (req_item.kind == KIND_POP_BACK) begin
                           rd_addr  = back_pos;
                           count_in = count_m1;
                        end else begin
                           rd_addr      = head_ff;
                           ptr_in       = ring_add(head_ff, ONE_IDX);
                           rem_in       = count_m1;
                           pend_last_in = (count_ff == ONE_CNT);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BUSY: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{status: STAT_OK, value_res: rd_data, last: pend_last_ff};
               pend_in      = 1'b0;
               if (pend_last_ff) begin
                  state_in = S_IDLE;
               end
            end
            if (issue) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_ff;
               ptr_in       = ring_add(ptr_ff, ONE_IDX);
               rem_in       = rem_ff - ONE_CNT;
               pend_in      = 1'b1;
               pend_last_in = (rem_ff == ONE_CNT);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff       <= ptr_in;
      pend_last_ff <= pend_last_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;
   assign stat.busy  = (state_ff == S_BUSY);
   assign stat.empty = is_empty;
   assign stat.full  = is_full;

endmodule
`default_nettype wire

// ----- hdl/double_ended_queue_top.sv -----
// A push's result appears in the cycle after acceptance; a pop's and the first of a list
// pass the read data register, then the result register; the rest follow one per cycle
// unless the result is stalled, set by the single read port and registered read data.
// A push is taken every cycle unless the result stalls; a pop or list blocks until done.
// Synchronous reset empties the queue at once (head and count to zero); the entry
// memory is not cleared, since no entry is read before it is written.
`default_nettype none
module double_ended_queue_top #(
   parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire dq_pkg::req_type req_item,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output dq_pkg::rsp_type      rsp_item
);
   import dq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] rd_data;
   stat_type                 stat;

   dq_mem #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dq_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .stat      (stat)
   );

`ifndef NO_ASSERTIONS
   // A push into a full queue is refused with a single flagged result.
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && stat.full &&
       (req_item.kind == KIND_PUSH_FRONT || req_item.kind == KIND_PUSH_BACK))
      |=> (rsp_valid && rsp_item.status == STAT_FULL && rsp_item.last))
      else $error("push on full queue not refused");

   // A pop or list on an empty queue reports empty at once.
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && stat.empty &&
       (req_item.kind == KIND_POP_FRONT || req_item.kind == KIND_POP_BACK ||
        req_item.kind == KIND_LIST))
      |=> (rsp_valid && rsp_item.status == STAT_EMPTY && rsp_item.last))
      else $error("pop or list on empty queue not reported");

   // A pop on a non-empty queue starts a memory read and a busy phase.
   a_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !stat.empty &&
       (req_item.kind == KIND_POP_FRONT || req_item.kind == KIND_POP_BACK))
      |=> (stat.busy && !stat.full))
      else $error("pop did not start a read");

   // The count can never be both zero and at capacity.
   a_count_sane: assert property (@(posedge clock) disable iff (reset)
      !(stat.empty && stat.full))
      else $error("entry count inconsistent");
`endif

endmodule
`default_nettype wire
